[rtl/rdv_pkg.sv]
`timescale 1ns / 1ps
package rdv_pkg;

    localparam int MAX_CONTAINERS_DEF = 4096;

    localparam logic [24:0] POS_CAP      = 25'd16777216;
    localparam logic [31:0] COOKIE_PLAIN = 32'd12346;
    localparam logic [15:0] COOKIE_RUN   = 16'd12347;
    localparam logic [16:0] ARRAY_MAX    = 17'd4096;
    localparam logic [13:0] BITSET_LAST  = 14'd8191;
    localparam logic [17:0] RUN_SPAN     = 18'h10000;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    typedef enum logic [4:0] {
        PH_LEN, PH_MAGIC, PH_NBUCKETS, PH_KEY, PH_COOKIE, PH_SIZE, PH_RUNBITS,
        PH_DESC, PH_OFFSETS, PH_NRUNS, PH_RUNPAIR, PH_ARRAY, PH_BITSET,
        PH_DONE, PH_CRC, PH_FETCH
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK, ST_TRUNC, ST_LENGTH, ST_MAGIC, ST_CRC, ST_COOKIE, ST_CONTAINERS,
        ST_RUNOVF, ST_ORDER, ST_BCOUNT, ST_LIMIT, ST_TRAILING, ST_SHORT
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [63:0] start;
        logic [16:0] len;
        t_status     st;
        logic [24:0] total;
        logic        last;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'hD1;
            2'd1:    m = 8'hD3;
            2'd2:    m = 8'h39;
            default: m = 8'h64;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] field_width(input t_phase ph);
        logic [3:0] w;
        unique case (ph)
            PH_NBUCKETS: w = 4'd8;
            PH_KEY, PH_COOKIE, PH_SIZE, PH_DESC, PH_RUNPAIR: w = 4'd4;
            PH_NRUNS, PH_ARRAY: w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

[rtl/roaring_deletion_vector_decoder.sv]
`timescale 1ns / 1ps
// Takes one blob byte per cycle unless the queue is full or a drain, fetch or status is pending.
// A run enters the output queue when its last byte is taken. A bitset byte holds the input
// while the runs for its set bits drain; entering a container holds it for the descriptor memory read.
// The final status word is queued after the last byte and any drain, and blob state clears with it.
// Reset is synchronous and active low: blob state clears, the cap returns to 16777216,
// and the descriptor memories are not cleared (no clearing pass).
module roaring_deletion_vector_decoder
    import rdv_pkg::*;
#(
    parameter int MAX_CONTAINERS = MAX_CONTAINERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [24:0]  i_cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // run_start, run_length, status, position_total, zero pad
    output logic         m_tuser,   // result_kind
    output logic         m_tlast
);

    localparam int CNT_W    = $clog2(MAX_CONTAINERS + 1);
    localparam int CA_W     = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1;
    localparam int RM_DEPTH = (MAX_CONTAINERS + 7) / 8;
    localparam int RA_W     = (RM_DEPTH > 1) ? $clog2(RM_DEPTH) : 1;
    localparam int CI_A     = (CNT_W > CA_W) ? CNT_W : CA_W;
    localparam int CI_W     = (CI_A > RA_W + 3) ? CI_A : RA_W + 3;
    localparam int SK_W     = CNT_W + 2;

    t_phase        r_phase, n_phase;
    t_status       r_err, n_err;
    logic [31:0]   r_count, n_count;
    logic [63:0]   r_field, n_field;
    logic [2:0]    r_pos, n_pos;
    logic [31:0]   r_vlen, n_vlen;
    logic [31:0]   r_crc, n_crc;
    logic [31:0]   r_bleft, n_bleft;
    logic [31:0]   r_prev, n_prev;
    logic          r_seen, n_seen;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CI_W-1:0]  r_cidx, n_cidx;
    logic [15:0]   r_ckey, n_ckey;
    logic [16:0]   r_items, n_items;
    logic [24:0]   r_emit, n_emit;
    logic [13:0]   r_walk, n_walk;
    logic [SK_W-1:0] r_skip, n_skip;
    logic          r_runs, n_runs;
    logic [7:0]    r_mask, n_mask;
    logic [3:0]    r_dcnt, n_dcnt;
    logic [60:0]   r_dbase, n_dbase;
    logic          r_fetch, n_fetch;
    logic          r_last, n_last;
    logic          r_fwd, n_fwd;
    logic [32:0]   r_fwd_data;
    logic [24:0]   r_maxpos;

    t_result       r_q0, r_q1;
    logic [1:0]    r_qcnt;
    logic          push_v, pop, slot_ok, accept, st_push;
    t_result       push_d;

    logic              dsc_we;
    logic [CA_W-1:0]   dsc_addr;
    logic [32:0]       dsc_wdata, dsc_rdata;
    logic              rm_we;
    logic [RA_W-1:0]   rm_addr;
    logic [7:0]        rm_rdata;

    assign slot_ok  = (r_qcnt != 2'd2);
    assign s_tready = slot_ok && (r_dcnt == 4'd0) && !r_fetch && !r_last;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (r_qcnt != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {2'b00, r_q0.total, r_q0.st, r_q0.len, r_q0.start};
    assign m_tuser  = r_q0.kind;
    assign m_tlast  = r_q0.last;

    rdv_ram #(.WIDTH(33), .DEPTH(MAX_CONTAINERS)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (dsc_we),
        .i_waddr (dsc_addr),
        .i_wdata (dsc_wdata),
        .i_raddr (n_cidx[CA_W-1:0]),
        .o_rdata (dsc_rdata)
    );

    rdv_ram #(.WIDTH(8), .DEPTH(RM_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_addr),
        .i_wdata (s_tdata),
        .i_raddr (n_cidx[RA_W+2:3]),
        .o_rdata (rm_rdata)
    );

    always_comb begin
        logic [7:0]  b;
        logic [32:0] i33;
        logic [32:0] vl3, vl4, vl8;
        logic [63:0] v;
        logic [3:0]  fw;
        logic        go_desc, go_off, go_cont, em_go;
        logic [CI_W-1:0] cont_i;
        logic [24:0] lim;
        logic [25:0] sum;
        logic [16:0] em_len, sz17, plen;
        logic [15:0] em_low;
        logic [3:0]  pop_n, dc;
        logic [2:0]  k;
        logic [SK_W-1:0] skip;
        logic [32:0] ent;
        t_status     st;

        n_phase = r_phase;   n_err = r_err;     n_count = r_count; n_field = r_field;
        n_pos = r_pos;       n_vlen = r_vlen;   n_crc = r_crc;     n_bleft = r_bleft;
        n_prev = r_prev;     n_seen = r_seen;   n_total = r_total; n_cidx = r_cidx;
        n_ckey = r_ckey;     n_items = r_items; n_emit = r_emit;   n_walk = r_walk;
        n_skip = r_skip;     n_runs = r_runs;   n_mask = r_mask;   n_dcnt = r_dcnt;
        n_dbase = r_dbase;   n_fetch = r_fetch; n_last = r_last;
        push_v = 1'b0;       push_d = '0;       st_push = 1'b0;
        dsc_we = 1'b0;       dsc_addr = r_cidx[CA_W-1:0];   dsc_wdata = '0;
        rm_we = 1'b0;        rm_addr = r_walk[RA_W-1:0];
        go_desc = 1'b0;      go_off = 1'b0;     go_cont = 1'b0;    em_go = 1'b0;
        cont_i = '0;         em_len = '0;       em_low = '0;       sz17 = '0;
        plen = '0;           pop_n = '0;        dc = '0;           k = '0;
        skip = '0;           ent = '0;          st = ST_OK;        sum = '0;
        v = '0;              fw = '0;
        b = s_tdata;
        lim = (r_maxpos > POS_CAP) ? POS_CAP : r_maxpos;
        i33 = {1'b0, r_count};
        vl3 = {1'b0, r_vlen} + 33'd3;
        vl4 = {1'b0, r_vlen} + 33'd4;
        vl8 = {1'b0, r_vlen} + 33'd8;

        if (accept) begin
            if (r_count < 32'd4) begin
                n_vlen = {r_vlen[23:0], b};
                if (r_count == 32'd3) begin
                    if ({r_vlen[23:0], b} < 32'd4) n_err = ST_LENGTH;
                    n_phase = PH_MAGIC;
                end
            end else if (r_err == ST_LENGTH) begin
                n_err = ST_LENGTH;
            end else if (i33 >= vl8 || r_count == 32'hFFFFFFFF) begin
                n_err = ST_LENGTH;
            end else if (i33 < vl4) begin
                n_crc = crc_byte(r_crc, b);
                if (r_count < 32'd8) begin
                    if (b != magic_byte(r_count[1:0]) && r_err == ST_OK) n_err = ST_MAGIC;
                    if (r_count == 32'd7) n_phase = PH_NBUCKETS;
                end else if (r_err == ST_OK) begin
                    unique case (r_phase)
                        PH_RUNBITS: begin
                            rm_we  = 1'b1;
                            n_walk = r_walk + 14'd1;
                            if (18'(r_walk) + 18'd1 >= ((18'(r_total) + 18'd7) >> 3))
                                go_desc = 1'b1;
                        end
                        PH_OFFSETS: begin
                            n_skip = r_skip - 1'b1;
                            if (r_skip == SK_W'(1)) go_cont = 1'b1;
                        end
                        PH_BITSET: begin
                            pop_n = 4'($countones(b));
                            sum   = 26'(r_emit) + 26'(pop_n);
                            if (sum > 26'(lim)) begin
                                // Cap reached inside the byte: only the bits that fit go out.
                                n_err = ST_LIMIT;
                                dc = (lim > r_emit) ? 4'(lim - r_emit) : 4'd0;
                            end else begin
                                dc = pop_n;
                                n_walk = r_walk + 14'd1;
                                if (r_walk == BITSET_LAST) begin
                                    go_cont = 1'b1;
                                    cont_i  = CI_W'(r_cidx + 1'b1);
                                end
                            end
                            n_dcnt  = dc;
                            n_mask  = b;
                            n_dbase = {r_prev, r_ckey, r_walk[12:0]};
                            n_emit  = r_emit + 25'(dc);
                        end
                        PH_DONE: n_err = ST_TRAILING;
                        default: begin
                            fw = field_width(r_phase);
                            if (fw != 4'd0) begin
                                v = r_field;
                                v[8*r_pos +: 8] = b;
                                n_pos   = r_pos + 3'd1;
                                n_field = v;
                                if (4'(r_pos) + 4'd1 == fw) begin
                                    n_field = '0;
                                    n_pos   = '0;
                                    unique case (r_phase)
                                        PH_NBUCKETS: begin
                                            if (v[63:32] != 32'd0) n_err = ST_BCOUNT;
                                            else begin
                                                n_bleft = v[31:0];
                                                n_phase = (v[31:0] == 32'd0) ? PH_DONE : PH_KEY;
                                            end
                                        end
                                        PH_KEY: begin
                                            if (r_seen && v[31:0] <= r_prev) n_err = ST_ORDER;
                                            else begin
                                                n_prev  = v[31:0];
                                                n_seen  = 1'b1;
                                                n_phase = PH_COOKIE;
                                            end
                                        end
                                        PH_COOKIE: begin
                                            if (v[31:0] == COOKIE_PLAIN) begin
                                                n_runs  = 1'b0;
                                                n_phase = PH_SIZE;
                                            end else if (v[15:0] == COOKIE_RUN) begin
                                                n_runs = 1'b1;
                                                sz17 = {1'b0, v[31:16]} + 17'd1;
                                                if (sz17 > 17'(MAX_CONTAINERS)) n_err = ST_CONTAINERS;
                                                else begin
                                                    n_total = CNT_W'(sz17);
                                                    n_walk  = '0;
                                                    n_phase = PH_RUNBITS;
                                                end
                                            end else begin
                                                n_err = ST_COOKIE;
                                            end
                                        end
                                        PH_SIZE: begin
                                            if (v[31:0] > 32'(MAX_CONTAINERS)) n_err = ST_CONTAINERS;
                                            else begin
                                                n_total = CNT_W'(v[31:0]);
                                                go_desc = 1'b1;
                                            end
                                        end
                                        PH_DESC: begin
                                            dsc_we    = 1'b1;
                                            dsc_wdata = {{1'b0, v[31:16]} + 17'd1, v[15:0]};
                                            n_cidx    = CI_W'(r_cidx + 1'b1);
                                            if (18'(r_cidx) + 18'd1 >= 18'(r_total)) go_off = 1'b1;
                                        end
                                        PH_NRUNS: begin
                                            if (v[15:0] == 16'd0) begin
                                                go_cont = 1'b1;
                                                cont_i  = CI_W'(r_cidx + 1'b1);
                                            end else begin
                                                n_items = {1'b0, v[15:0]};
                                                n_phase = PH_RUNPAIR;
                                            end
                                        end
                                        PH_RUNPAIR: begin
                                            plen = {1'b0, v[31:16]} + 17'd1;
                                            if (18'(v[15:0]) + 18'(plen) > RUN_SPAN) n_err = ST_RUNOVF;
                                            else begin
                                                em_go  = 1'b1;
                                                em_low = v[15:0];
                                                em_len = plen;
                                            end
                                        end
                                        PH_ARRAY: begin
                                            em_go  = 1'b1;
                                            em_low = v[15:0];
                                            em_len = 17'd1;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                        end
                    endcase

                    if (em_go) begin
                        sum = 26'(r_emit) + 26'(em_len);
                        if (sum > 26'(lim)) begin
                            n_err = ST_LIMIT;
                        end else begin
                            push_v       = 1'b1;
                            push_d.start = {r_prev, r_ckey, em_low};
                            push_d.len   = em_len;
                            n_emit       = r_emit + 25'(em_len);
                            n_items      = r_items - 17'd1;
                            if (r_items == 17'd1) begin
                                go_cont = 1'b1;
                                cont_i  = CI_W'(r_cidx + 1'b1);
                            end
                        end
                    end

                    // Structure transitions: descriptors, then offsets, then a container.
                    if (go_desc) begin
                        n_cidx = '0;
                        if (n_total == '0) go_off = 1'b1;
                        else n_phase = PH_DESC;
                    end
                    if (go_off) begin
                        skip = (!n_runs || 18'(n_total) >= 18'd4) ? SK_W'({n_total, 2'b00}) : '0;
                        if (skip == '0) begin
                            go_cont = 1'b1;
                            cont_i  = '0;
                        end else begin
                            n_skip  = skip;
                            n_phase = PH_OFFSETS;
                        end
                    end
                    if (go_cont) begin
                        n_cidx = cont_i;
                        if (18'(cont_i) >= 18'(n_total)) begin
                            n_bleft = r_bleft - 32'd1;
                            n_phase = (r_bleft == 32'd1) ? PH_DONE : PH_KEY;
                        end else begin
                            n_fetch = 1'b1;
                            n_phase = PH_FETCH;
                        end
                    end
                end
                if (i33 == vl3) begin
                    if (n_err == ST_OK && n_phase != PH_DONE) n_err = ST_TRUNC;
                    n_phase = PH_CRC;
                    n_field = '0;
                    n_pos   = '0;
                    n_fetch = 1'b0;
                end
            end else begin
                n_field = {32'd0, r_field[23:0], b};
            end
            if (r_count != 32'hFFFFFFFF) n_count = r_count + 32'd1;
            if (s_tlast) begin
                n_last  = 1'b1;
                n_fetch = 1'b0;
            end
        end else if (r_dcnt != 4'd0) begin
            if (slot_ok) begin
                for (int j = 7; j >= 0; j--) begin
                    if (r_mask[j]) k = 3'(j);
                end
                push_v       = 1'b1;
                push_d.start = {r_dbase, k};
                push_d.len   = 17'd1;
                n_mask       = r_mask & ~(8'd1 << k);
                n_dcnt       = r_dcnt - 4'd1;
            end
        end else if (r_fetch) begin
            ent     = r_fwd ? r_fwd_data : dsc_rdata;
            n_ckey  = ent[15:0];
            n_fetch = 1'b0;
            if (r_runs && rm_rdata[r_cidx[2:0]]) begin
                n_phase = PH_NRUNS;
            end else if (ent[32:16] <= ARRAY_MAX) begin
                n_items = ent[32:16];
                n_phase = PH_ARRAY;
            end else begin
                n_walk  = '0;
                n_phase = PH_BITSET;
            end
        end else if (r_last && slot_ok) begin
            if (r_count < 32'd12) st = ST_SHORT;
            else if (r_err == ST_LENGTH || {1'b0, r_count} != vl8) st = ST_LENGTH;
            else if (r_err == ST_MAGIC) st = ST_MAGIC;
            else if (r_field != {32'd0, ~r_crc}) st = ST_CRC;
            else st = r_err;
            push_v       = 1'b1;
            st_push      = 1'b1;
            push_d.kind  = 1'b1;
            push_d.st    = st;
            push_d.total = r_emit;
            push_d.last  = 1'b1;
            n_phase = PH_LEN;  n_err = ST_OK;  n_count = '0;   n_field = '0;
            n_pos = '0;        n_vlen = '0;    n_crc = CRC_INIT; n_bleft = '0;
            n_prev = '0;       n_seen = 1'b0;  n_total = '0;   n_cidx = '0;
            n_items = '0;      n_emit = '0;    n_walk = '0;    n_skip = '0;
            n_runs = 1'b0;     n_last = 1'b0;
        end

        n_fwd = dsc_we && (dsc_addr == n_cidx[CA_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;  r_err <= ST_OK;    r_count <= '0;  r_field <= '0;
            r_pos <= '0;        r_vlen <= '0;      r_crc <= CRC_INIT; r_bleft <= '0;
            r_prev <= '0;       r_seen <= 1'b0;    r_total <= '0;  r_cidx <= '0;
            r_items <= '0;      r_emit <= '0;      r_walk <= '0;   r_skip <= '0;
            r_runs <= 1'b0;     r_mask <= '0;      r_dcnt <= '0;   r_fetch <= 1'b0;
            r_last <= 1'b0;     r_fwd <= 1'b0;     r_maxpos <= POS_CAP;
            r_qcnt <= '0;
        end else begin
            r_phase <= n_phase; r_err <= n_err;    r_count <= n_count; r_field <= n_field;
            r_pos <= n_pos;     r_vlen <= n_vlen;  r_crc <= n_crc;     r_bleft <= n_bleft;
            r_prev <= n_prev;   r_seen <= n_seen;  r_total <= n_total; r_cidx <= n_cidx;
            r_items <= n_items; r_emit <= n_emit;  r_walk <= n_walk;   r_skip <= n_skip;
            r_runs <= n_runs;   r_mask <= n_mask;  r_dcnt <= n_dcnt;   r_fetch <= n_fetch;
            r_last <= n_last;   r_fwd <= n_fwd;
            if (i_cfg_wr_en) r_maxpos <= i_cfg_wr_data;
            r_qcnt <= r_qcnt - {1'b0, pop} + {1'b0, push_v};
        end
    end

    // Payload registers and the two-word output queue.
    always_ff @(posedge i_clk) begin
        r_ckey     <= n_ckey;
        r_dbase    <= n_dbase;
        r_fwd_data <= dsc_wdata;
        if (pop && r_qcnt == 2'd2) r_q0 <= r_q1;
        if (push_v) begin
            if (r_qcnt - {1'b0, pop} == 2'd0) r_q0 <= push_d;
            else r_q1 <= push_d;
        end
    end

    a_drain_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        4'($countones(r_mask)) >= r_dcnt)
        else $error("drain count exceeds the remaining set bits");

    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("output queue overfilled");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (r_dcnt == 4'd0 && !r_fetch && !r_last))
        else $error("input ready while a word is still being worked");

    a_fetch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch |-> r_phase == PH_FETCH)
        else $error("descriptor fetch outside the fetch phase");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_push |=> (r_phase == PH_LEN && r_emit == 25'd0 && r_count == 32'd0))
        else $error("blob state not cleared after the status word");

endmodule

[rtl/rdv_ram.sv]
`timescale 1ns / 1ps
module rdv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the entry being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
